// ----- sv/rfvd_pkg.sv -----
// ----------------------------------------------------------------------------
// rfvd_pkg
// Shared widths, types and arithmetic helpers for the radial falloff
// vertex displacement pipeline.
// ----------------------------------------------------------------------------
package rfvd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MAG_W     = COORD_W;
    localparam int RAD_W     = 31;
    localparam int R2_W      = 2 * RAD_W;
    localparam int REM_W     = R2_W + 1;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int PROD_W    = MAG_W + FRAC_BITS;
    localparam int RES_W     = COORD_W + 2;

    localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(65536);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [2:0][COORD_W-1:0]   t_vec;
    typedef logic [2:0][MAG_W-1:0]     t_mag3;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    typedef struct packed {
        logic       hit;
        t_vec       v;
        logic [2:0] dneg;
        t_mag3      dmag;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             qbit;
    } t_div_step;

    function automatic t_diff diff33(input t_coord a, input t_coord b);
        return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    function automatic logic [MAG_W-1:0] mag33(input t_diff d);
        t_diff n;
        n = -d;
        return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

    // one restoring division step
    function automatic t_div_step div_step(input logic [REM_W-1:0] rem,
                                           input logic [R2_W-1:0]  den);
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] d;
        t_div_step        s;
        sh = {rem[REM_W-2:0], 1'b0};
        d  = {1'b0, den};
        if (sh >= d) begin
            s.rem  = sh - d;
            s.qbit = 1'b1;
        end else begin
            s.rem  = sh;
            s.qbit = 1'b0;
        end
        return s;
    endfunction

endpackage

// ----- sv/rfvd_if.sv -----
// ----------------------------------------------------------------------------
// rfvd_if
// Valid/ready channels of the radial falloff vertex displacement block:
// vertex input, displaced vertex output and radius configuration.
// ----------------------------------------------------------------------------
interface rfvd_in_if;
    import rfvd_pkg::*;

    logic   valid;
    logic   ready;
    t_coord vertex_x;
    t_coord vertex_y;
    t_coord vertex_z;
    t_coord target_x;
    t_coord target_y;
    t_coord target_z;
    t_coord origin_x;
    t_coord origin_y;
    t_coord origin_z;

    modport source (
        output valid, vertex_x, vertex_y, vertex_z, target_x, target_y, target_z,
               origin_x, origin_y, origin_z,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, vertex_z, target_x, target_y, target_z,
               origin_x, origin_y, origin_z,
        output ready
    );
endinterface

interface rfvd_out_if;
    import rfvd_pkg::*;

    logic   valid;
    logic   ready;
    logic   inside_radius;
    t_coord new_x;
    t_coord new_y;
    t_coord new_z;
    logic   saturated;

    modport source (
        output valid, inside_radius, new_x, new_y, new_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, inside_radius, new_x, new_y, new_z, saturated,
        output ready
    );
endinterface

interface rfvd_cfg_if;
    import rfvd_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- sv/rfvd_div.sv -----
// ----------------------------------------------------------------------------
// rfvd_div
// Pipelined restoring divider for the falloff factor: one quotient bit per
// stage, side data travels with each stage, per-stage stall handling.
// ----------------------------------------------------------------------------
module rfvd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rfvd_pkg::R2_W-1:0]     i_num,
    input  logic [rfvd_pkg::R2_W-1:0]     i_den,
    input  rfvd_pkg::t_side               i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rfvd_pkg::FRAC_BITS-1:0] o_quot,
    output rfvd_pkg::t_side               o_side
);
    import rfvd_pkg::*;

    logic [FRAC_BITS-1:0] r_v;
    logic [REM_W-1:0]     r_rem  [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_q    [FRAC_BITS];
    t_side                r_side [FRAC_BITS];

    logic [FRAC_BITS:0]   w_en;
    logic [FRAC_BITS-1:0] w_v_in;
    logic [REM_W-1:0]     w_rem_in  [FRAC_BITS];
    logic [FRAC_BITS-1:0] w_q_in    [FRAC_BITS];
    t_side                w_side_in [FRAC_BITS];
    t_div_step            w_step    [FRAC_BITS];

    // a stage moves when it is empty or the next one moves
    always_comb begin
        w_en[FRAC_BITS] = i_ready;
        for (int j = FRAC_BITS - 1; j >= 0; j--) begin
            w_en[j] = !r_v[j] || w_en[j+1];
        end
    end

    always_comb begin
        w_v_in[0]    = i_valid;
        w_rem_in[0]  = {1'b0, i_num};
        w_q_in[0]    = '0;
        w_side_in[0] = i_side;
        for (int j = 1; j < FRAC_BITS; j++) begin
            w_v_in[j]    = r_v[j-1];
            w_rem_in[j]  = r_rem[j-1];
            w_q_in[j]    = r_q[j-1];
            w_side_in[j] = r_side[j-1];
        end
        for (int j = 0; j < FRAC_BITS; j++) begin
            w_step[j] = div_step(w_rem_in[j], i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < FRAC_BITS; j++) begin
                if (w_en[j]) begin
                    r_v[j] <= w_v_in[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < FRAC_BITS; j++) begin
            if (w_en[j]) begin
                r_rem[j]  <= w_step[j].rem;
                r_q[j]    <= {w_q_in[j][FRAC_BITS-2:0], w_step[j].qbit};
                r_side[j] <= w_side_in[j];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[FRAC_BITS-1];
    assign o_quot  = r_q[FRAC_BITS-1];
    assign o_side  = r_side[FRAC_BITS-1];

    // remainder reaches the divisor only when the dividend equals it
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_den != '0) |-> (r_rem[FRAC_BITS-1] <= {1'b0, i_den}))
        else $error("divider remainder above divisor");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v && !i_ready))
        else $error("divider stalls with an empty stage");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (r_v == '0))
        else $error("divider holds data after reset");

endmodule

// ----- sv/radial_falloff_vertex_displace.sv -----
// ----------------------------------------------------------------------------
// radial_falloff_vertex_displace
// Moves each vertex by (target - origin) scaled with the quadratic falloff
// 1 - d^2/r^2 when it lies strictly inside the radius around the target.
//
// Usage:
//   i_in  : one transaction per vertex carrying vertex, target and origin,
//           signed fixed point with FRAC_BITS fractional bits
//   o_out : one transaction per vertex, in order: inside flag, new
//           coordinates clamped to 32 bits, and a clamp flag
//   i_cfg : radius write, always ready; write it only while no vertex is
//           in flight
// Pipeline: the four distance stages, one divider stage per quotient bit,
//   and the scale, round and clamp stages.
// Throughput: one vertex per cycle while o_out does not stall; every
//   stage has its own valid bit.
// Reset: all stages empty, radius back to 1.0.
// Receiver stall: the result holds on o_out; earlier stages keep filling
//   their empty slots, and i_in.ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module radial_falloff_vertex_displace (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfvd_cfg_if.sink   i_cfg,
    rfvd_in_if.sink    i_in,
    rfvd_out_if.source o_out
);
    import rfvd_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic [R2_W-1:0]  r_r2;

    logic                    r_a_v, r_b_v, r_c_v, r_d_v, r_m_v, r_r_v, r_s_v;
    t_side                   r_a_side, r_b_side, r_c_side, r_d_side, r_m_side, r_r_side;
    t_mag3                   r_a_dm;
    logic [2:0][SQ_W-1:0]    r_b_sq;
    logic [SUM_W-1:0]        r_c_sum;
    logic [R2_W-1:0]         r_d_num;
    logic [2:0][PROD_W-1:0]  r_m_prod;
    t_mag3                   r_r_rnd;
    logic                    r_s_inside;
    t_vec                    r_s_new;
    logic                    r_s_sat;

    logic en_a, en_b, en_c, en_d, en_m, en_r, en_s;
    logic w_div_ready, w_div_valid;
    logic [FRAC_BITS-1:0] w_div_c;
    t_side w_div_side;

    t_side                n_a_side;
    t_mag3                n_a_dm;
    logic                 n_d_inside;
    t_side                n_d_side;
    t_vec                 n_s_new;
    logic                 n_s_sat;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg.valid) begin
            r_radius <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= R2_W'(r_radius) * R2_W'(r_radius);
    end

    // stall chain
    assign en_s = !r_s_v || o_out.ready;
    assign en_r = !r_r_v || en_s;
    assign en_m = !r_m_v || en_r;
    assign en_d = !r_d_v || w_div_ready;
    assign en_c = !r_c_v || en_d;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;
    assign i_in.ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_m_v <= 1'b0;
            r_r_v <= 1'b0;
            r_s_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_in.valid;
            if (en_b) r_b_v <= r_a_v;
            if (en_c) r_c_v <= r_b_v;
            if (en_d) r_d_v <= r_c_v;
            if (en_m) r_m_v <= w_div_valid;
            if (en_r) r_r_v <= r_m_v;
            if (en_s) r_s_v <= r_r_v;
        end
    end

    // stage a: differences
    always_comb begin
        t_diff dto [3];
        t_diff dtv [3];
        dto[0] = diff33(i_in.target_x, i_in.origin_x);
        dto[1] = diff33(i_in.target_y, i_in.origin_y);
        dto[2] = diff33(i_in.target_z, i_in.origin_z);
        dtv[0] = diff33(i_in.target_x, i_in.vertex_x);
        dtv[1] = diff33(i_in.target_y, i_in.vertex_y);
        dtv[2] = diff33(i_in.target_z, i_in.vertex_z);
        n_a_side.hit  = 1'b0;
        n_a_side.v[0] = i_in.vertex_x;
        n_a_side.v[1] = i_in.vertex_y;
        n_a_side.v[2] = i_in.vertex_z;
        for (int k = 0; k < 3; k++) begin
            n_a_side.dneg[k] = dto[k][DIFF_W-1];
            n_a_side.dmag[k] = mag33(dto[k]);
            n_a_dm[k]        = mag33(dtv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_side <= n_a_side;
            r_a_dm   <= n_a_dm;
        end
    end

    // stage b: squares
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_side <= r_a_side;
            for (int k = 0; k < 3; k++) begin
                r_b_sq[k] <= SQ_W'(r_a_dm[k]) * SQ_W'(r_a_dm[k]);
            end
        end
    end

    // stage c: squared distance
    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_side <= r_b_side;
            r_c_sum  <= SUM_W'(r_b_sq[0]) + SUM_W'(r_b_sq[1]) + SUM_W'(r_b_sq[2]);
        end
    end

    // stage d: radius test and dividend
    assign n_d_inside = (r_c_sum < SUM_W'(r_r2));

    always_comb begin
        n_d_side     = r_c_side;
        n_d_side.hit = n_d_inside;
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_side <= n_d_side;
            r_d_num  <= n_d_inside ? (r_r2 - r_c_sum[R2_W-1:0]) : '0;
        end
    end

    rfvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .o_ready (w_div_ready),
        .i_num   (r_d_num),
        .i_den   (r_r2),
        .i_side  (r_d_side),
        .o_valid (w_div_valid),
        .i_ready (en_m),
        .o_quot  (w_div_c),
        .o_side  (w_div_side)
    );

    // stage m: scale by falloff
    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_m_side <= w_div_side;
            for (int k = 0; k < 3; k++) begin
                r_m_prod[k] <= PROD_W'(w_div_side.dmag[k]) * PROD_W'(w_div_c);
            end
        end
    end

    // stage r: round half away from zero on the magnitude
    always_ff @(posedge i_clk) begin
        if (en_r) begin
            r_r_side <= r_m_side;
            for (int k = 0; k < 3; k++) begin
                logic [PROD_W:0] s;
                s = {1'b0, r_m_prod[k]} + {1'b0, ROUND_HALF};
                r_r_rnd[k] <= s[FRAC_BITS +: MAG_W];
            end
        end
    end

    // stage s: add, clamp, select
    always_comb begin
        logic signed [RES_W-1:0] vx;
        logic signed [RES_W-1:0] dx;
        logic signed [RES_W-1:0] sum;
        logic                    over;
        n_s_sat = 1'b0;
        vx      = '0;
        dx      = '0;
        sum     = '0;
        over    = 1'b0;
        for (int k = 0; k < 3; k++) begin
            vx   = RES_W'($signed(r_r_side.v[k]));
            dx   = $signed({2'b00, r_r_rnd[k]});
            sum  = r_r_side.dneg[k] ? (vx - dx) : (vx + dx);
            over = (sum[RES_W-1:COORD_W-1] != '0) && (sum[RES_W-1:COORD_W-1] != '1);
            if (!r_r_side.hit) begin
                n_s_new[k] = r_r_side.v[k];
            end else if (over) begin
                n_s_new[k] = sum[RES_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                          : {1'b0, {(COORD_W-1){1'b1}}};
                n_s_sat    = 1'b1;
            end else begin
                n_s_new[k] = sum[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s) begin
            r_s_inside <= r_r_side.hit;
            r_s_new    <= n_s_new;
            r_s_sat    <= n_s_sat;
        end
    end

    assign o_out.valid         = r_s_v;
    assign o_out.inside_radius = r_s_inside;
    assign o_out.new_x         = r_s_new[0];
    assign o_out.new_y         = r_s_new[1];
    assign o_out.new_z         = r_s_new[2];
    assign o_out.saturated     = r_s_sat;

    a_sat_needs_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.inside_radius || !o_out.saturated))
        else $error("clamp flagged on a vertex outside the radius");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_radius == '0) |-> !o_out.inside_radius)
        else $error("vertex inside a zero radius");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_a_v && r_b_v && r_c_v && r_d_v && o_out.valid && !o_out.ready))
        else $error("input stalled while the pipeline has room");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

endmodule
